// ===== hdl/gps_pkg.sv =====
// Shared constants, codes and inter-module structs for the parent selector.
// Used by every file of the block by scoped names; depends on nothing.
package gps_pkg;

   localparam int MAX_POPULATION = 1024;
   localparam int IDX_W          = $clog2(MAX_POPULATION);
   localparam int POP_W          = $clog2(MAX_POPULATION + 1);
   localparam int COST_W         = 32;
   localparam int TOTAL_W        = 42;
   localparam int RND_W          = 31;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 11;
   localparam int DIV_STEPS      = RND_W;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_DRAW  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_ROULETTE   = 2'd0,
      MODE_TOURNAMENT = 2'd1,
      MODE_RANDOM     = 2'd2,
      MODE_TRUNCATE   = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE    = 2'd0,
      REG_POP     = 2'd1,
      REG_CONTEST = 2'd2,
      REG_KEEP    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [COST_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic               start;
      logic [RND_W-1:0]   dividend;
      logic [TOTAL_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [RND_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== hdl/gps_if.sv =====
// Valid/ready channel interfaces for draw/write requests and selection responses.
// Depends on gps_pkg for field widths.
interface gps_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [gps_pkg::IDX_W-1:0]  entry_index;
   logic [gps_pkg::COST_W-1:0] cost_value;
   logic [gps_pkg::RND_W-1:0]  random_value;

   modport source (output valid, output operation, output entry_index,
                   output cost_value, output random_value, input ready);
   modport sink   (input valid, input operation, input entry_index,
                   input cost_value, input random_value, output ready);
endinterface

interface gps_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [gps_pkg::IDX_W-1:0] selected_index;
   logic                      status;

   modport source (output valid, output selected_index, output status, input ready);
   modport sink   (input valid, input selected_index, input status, output ready);
endinterface

// ===== hdl/gps_cost_ram.sv =====
// Cost table: one write port, one read port, registered read data.
// Depends on gps_pkg for depth, widths and the write-port struct.
module gps_cost_ram (
   input  logic                       clock,
   input  gps_pkg::ram_wr_type        wr,
   input  logic [gps_pkg::IDX_W-1:0]  rd_addr,
   output logic [gps_pkg::COST_W-1:0] rd_data
);

   logic [gps_pkg::COST_W-1:0] mem [gps_pkg::MAX_POPULATION];
   logic [gps_pkg::COST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gps_divider.sv =====
// Restoring remainder unit, one dividend bit per cycle.
// Depends on gps_pkg for widths and command/response structs.
module gps_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gps_pkg::div_cmd_type cmd,
   output gps_pkg::div_rsp_type rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [gps_pkg::DIV_CNT_W-1:0]     step_ff, step_in;
   logic [gps_pkg::RND_W-1:0]         dvd_ff, dvd_in;
   logic [gps_pkg::RND_W-1:0]         rem_ff, rem_in;
   logic [gps_pkg::TOTAL_W-1:0]       dvs_ff, dvs_in;
   logic [gps_pkg::RND_W:0]           shifted;
   logic [gps_pkg::TOTAL_W:0]         trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, dvd_ff[gps_pkg::RND_W-1]};
      trial   = {{(gps_pkg::TOTAL_W - gps_pkg::RND_W){1'b0}}, shifted}
                - {1'b0, dvs_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[gps_pkg::RND_W-2:0], 1'b0};
         // partial remainder never exceeds the partial dividend, so it fits RND_W
         rem_in = trial[gps_pkg::TOTAL_W] ? shifted[gps_pkg::RND_W-1:0]
                                          : trial[gps_pkg::RND_W-1:0];
         step_in = step_ff + gps_pkg::DIV_CNT_W'(1);
         if (step_ff == gps_pkg::DIV_CNT_W'(gps_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== hdl/ga_parent_selector.sv =====
// Parent selector top level: config registers, sequencer, cost table and remainder unit.
// Depends on gps_pkg, gps_if (gps_req_if, gps_rsp_if), gps_cost_ram and gps_divider.
//
//  channel   dir  beat contents                                        handshake
//  req_chan  in   operation, entry_index, cost_value, random_value     valid/ready
//  rsp_chan  out  selected_index, status (one beat per chosen parent)  valid/ready
//  csr_*     in   csr_index, csr_data                                  csr_we, no stall
//
// One request beat at a time. Cost write: read old cost on accept, then write back + total.
// Roulette: random mod total in the remainder unit (31 steps, then done), then a walk of up to 1024
// prefix-sum entries, one entry per cycle from the cost RAM, then count mod population.
// Tournament, uniform and truncation draws each take one pass of the bit-serial remainder
// unit. After reset a clearing pass zeroes the cost RAM with req_chan.ready low.
// A finished result waits in the response register; the next request is taken while it
// waits, a second result stalls until it drains.
module ga_parent_selector (
   input  logic                             clock,
   input  logic                             reset,
   gps_req_if.sink                          req_chan,
   gps_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [gps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0]   csr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_UPD,
      ST_RL_DIV,
      ST_RL_WALK,
      ST_SEL_DIV,
      ST_TN_DIV,
      ST_TN_RDC,
      ST_TN_RDL,
      ST_DONE
   } state_type;

   localparam int IDX_W   = gps_pkg::IDX_W;
   localparam int POP_W   = gps_pkg::POP_W;
   localparam int COST_W  = gps_pkg::COST_W;
   localparam int TOTAL_W = gps_pkg::TOTAL_W;
   localparam int RND_W   = gps_pkg::RND_W;

   state_type                 state_ff, state_in;

   // configuration
   gps_pkg::mode_type         mode_ff, mode_in;
   logic [POP_W-1:0]          pop_size_ff, pop_size_in;
   logic [POP_W-1:0]          contest_ff, contest_in;
   logic [POP_W-1:0]          keep_ff, keep_in;

   // persistent state
   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic [IDX_W-1:0]          leader_ff, leader_in;
   logic [POP_W-1:0]          draws_ff, draws_in;
   logic [IDX_W-1:0]          clr_ptr_ff, clr_ptr_in;

   // per-item working registers
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [COST_W-1:0]         cost_ff, cost_in;
   logic                      write_ok_ff, write_ok_in;
   logic [RND_W-1:0]          spot_ff, spot_in;
   logic [TOTAL_W-1:0]        sum_ff, sum_in;
   logic [POP_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          cand_ff, cand_in;
   logic [COST_W-1:0]         cand_cost_ff, cand_cost_in;
   logic [IDX_W-1:0]          sel_ff, sel_in;
   logic                      status_ff, status_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          rsp_sel_ff, rsp_sel_in;
   logic                      rsp_status_ff, rsp_status_in;

   // datapath wires
   logic [POP_W-1:0]          eff_pop;
   logic [POP_W-1:0]          eff_keep;
   logic [POP_W-1:0]          need;
   logic [TOTAL_W-1:0]        sum_next;
   logic [POP_W-1:0]          count_next;
   logic [POP_W-1:0]          draws_next;
   logic [IDX_W-1:0]          leader_next;
   logic                      tn_finish;
   logic [IDX_W-1:0]          rd_addr;
   logic [COST_W-1:0]         rd_data;
   gps_pkg::ram_wr_type       ram_wr;
   gps_pkg::div_cmd_type      div_cmd;
   gps_pkg::div_rsp_type      div_rsp;

   gps_cost_ram u_cost_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gps_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // clamped sizes
   always_comb begin
      if (pop_size_ff == '0) begin
         eff_pop = POP_W'(1);
      end else if (pop_size_ff > POP_W'(gps_pkg::MAX_POPULATION)) begin
         eff_pop = POP_W'(gps_pkg::MAX_POPULATION);
      end else begin
         eff_pop = pop_size_ff;
      end
      eff_keep = (keep_ff == '0) ? POP_W'(1) : keep_ff;
      if (eff_keep > eff_pop) begin
         eff_keep = eff_pop;
      end
      need = (contest_ff == '0) ? POP_W'(1) : contest_ff;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      pop_size_in   = pop_size_ff;
      contest_in    = contest_ff;
      keep_in       = keep_ff;
      total_in      = total_ff;
      leader_in     = leader_ff;
      draws_in      = draws_ff;
      clr_ptr_in    = clr_ptr_ff;
      idx_in        = idx_ff;
      cost_in       = cost_ff;
      write_ok_in   = write_ok_ff;
      spot_in       = spot_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      cand_in       = cand_ff;
      cand_cost_in  = cand_cost_ff;
      sel_in        = sel_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_sel_in    = rsp_sel_ff;
      rsp_status_in = rsp_status_ff;

      ram_wr      = '0;
      div_cmd     = '0;
      rd_addr     = '0;
      tn_finish   = 1'b0;
      leader_next = leader_ff;
      sum_next    = sum_ff + {{(TOTAL_W - COST_W){1'b0}}, rd_data};
      count_next  = count_ff + POP_W'(1);
      draws_next  = draws_ff + POP_W'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one RAM entry per cycle after reset
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_ptr_ff;
            ram_wr.data = '0;
            clr_ptr_in  = clr_ptr_ff + IDX_W'(1);
            if (clr_ptr_ff == IDX_W'(gps_pkg::MAX_POPULATION - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // old cost is fetched on accept for the write path
            rd_addr = req_chan.entry_index;
            if (req_chan.valid) begin
               idx_in      = req_chan.entry_index;
               cost_in     = req_chan.cost_value;
               write_ok_in = {1'b0, req_chan.entry_index} < eff_pop;
               status_in   = 1'b0;
               if (gps_pkg::op_type'(req_chan.operation) == gps_pkg::OP_WRITE) begin
                  state_in = ST_WR_UPD;
               end else begin
                  div_cmd.dividend = req_chan.random_value;
                  div_cmd.divisor  = {{(TOTAL_W - POP_W){1'b0}}, eff_pop};
                  unique case (mode_ff)
                     gps_pkg::MODE_ROULETTE: begin
                        if (total_ff == '0) begin
                           sel_in    = '0;
                           status_in = 1'b1;
                           state_in  = ST_DONE;
                        end else begin
                           div_cmd.start   = 1'b1;
                           div_cmd.divisor = total_ff;
                           state_in        = ST_RL_DIV;
                        end
                     end
                     gps_pkg::MODE_TOURNAMENT: begin
                        div_cmd.start = 1'b1;
                        state_in      = ST_TN_DIV;
                     end
                     gps_pkg::MODE_RANDOM: begin
                        div_cmd.start = 1'b1;
                        state_in      = ST_SEL_DIV;
                     end
                     gps_pkg::MODE_TRUNCATE: begin
                        div_cmd.start   = 1'b1;
                        div_cmd.divisor = {{(TOTAL_W - POP_W){1'b0}}, eff_keep};
                        state_in        = ST_SEL_DIV;
                     end
                  endcase
               end
            end
         end
         ST_WR_UPD: begin
            // out-of-range writes are dropped
            if (write_ok_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = idx_ff;
               ram_wr.data = cost_ff;
               total_in    = total_ff - {{(TOTAL_W - COST_W){1'b0}}, rd_data}
                             + {{(TOTAL_W - COST_W){1'b0}}, cost_ff};
            end
            state_in = ST_IDLE;
         end
         ST_RL_DIV: begin
            // entry 0 is prefetched while the spot is computed
            rd_addr  = '0;
            sum_in   = '0;
            count_in = '0;
            if (div_rsp.done) begin
               spot_in = div_rsp.remainder;
               if (div_rsp.remainder == '0) begin
                  sel_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RL_WALK;
               end
            end
         end
         ST_RL_WALK: begin
            // rd_data holds entry count_ff; prefetch the next one
            rd_addr  = count_ff[IDX_W-1:0] + IDX_W'(1);
            sum_in   = sum_next;
            count_in = count_next;
            if (!(({{(TOTAL_W - RND_W){1'b0}}, spot_ff} > sum_next) &&
                  (count_next < POP_W'(gps_pkg::MAX_POPULATION)))) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = {{(RND_W - POP_W){1'b0}}, count_next};
               div_cmd.divisor  = {{(TOTAL_W - POP_W){1'b0}}, eff_pop};
               state_in         = ST_SEL_DIV;
            end
         end
         ST_SEL_DIV: begin
            if (div_rsp.done) begin
               sel_in   = div_rsp.remainder[IDX_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_TN_DIV: begin
            rd_addr = div_rsp.remainder[IDX_W-1:0];
            if (div_rsp.done) begin
               cand_in = div_rsp.remainder[IDX_W-1:0];
               if (draws_ff == '0) begin
                  leader_next = div_rsp.remainder[IDX_W-1:0];
                  tn_finish   = 1'b1;
               end else begin
                  state_in = ST_TN_RDC;
               end
            end
         end
         ST_TN_RDC: begin
            cand_cost_in = rd_data;
            rd_addr      = leader_ff;
            state_in     = ST_TN_RDL;
         end
         ST_TN_RDL: begin
            // strict compare: ties keep the current leader
            if (cand_cost_ff < rd_data) begin
               leader_next = cand_ff;
            end
            tn_finish = 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sel_in    = sel_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (tn_finish) begin
         leader_in = leader_next;
         if (draws_next < need) begin
            draws_in = draws_next;
            state_in = ST_IDLE;
         end else begin
            draws_in = '0;
            sel_in   = leader_next;
            state_in = ST_DONE;
         end
      end

      // register writes must only arrive while idle; the block itself does not enforce this
      if (csr_we) begin
         unique case (gps_pkg::reg_index_type'(csr_index))
            gps_pkg::REG_MODE: begin
               mode_in  = gps_pkg::mode_type'(csr_data[1:0]);
               draws_in = '0;
            end
            gps_pkg::REG_POP: begin
               pop_size_in = csr_data;
            end
            gps_pkg::REG_CONTEST: begin
               contest_in = csr_data;
               draws_in   = '0;
            end
            gps_pkg::REG_KEEP: begin
               keep_in = csr_data;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cost_ff      <= cost_in;
      write_ok_ff  <= write_ok_in;
      spot_ff      <= spot_in;
      sum_ff       <= sum_in;
      count_ff     <= count_in;
      cand_ff      <= cand_in;
      cand_cost_ff <= cand_cost_in;
      sel_ff       <= sel_in;
      status_ff    <= status_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mode_ff      <= gps_pkg::MODE_ROULETTE;
         pop_size_ff  <= POP_W'(gps_pkg::MAX_POPULATION);
         contest_ff   <= POP_W'(2);
         keep_ff      <= POP_W'(1);
         total_ff     <= '0;
         leader_ff    <= '0;
         draws_ff     <= '0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pop_size_ff  <= pop_size_in;
         contest_ff   <= contest_in;
         keep_ff      <= keep_in;
         total_ff     <= total_in;
         leader_ff    <= leader_in;
         draws_ff     <= draws_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.selected_index = rsp_sel_ff;
   assign rsp_chan.status         = rsp_status_ff;

endmodule

// ===== hdl/gps_checker.sv =====
// Port-level checks for ga_parent_selector, attached by the bind at the end.
// Depends on gps_pkg for widths and operation codes.
module gps_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_operation,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [gps_pkg::IDX_W-1:0] rsp_selected_index,
   input logic                      rsp_status
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_selected_index)
                                  && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // clearing pass keeps requests out right after reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // one item at a time: busy in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken back to back");

   // a cost write never produces a response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (gps_pkg::op_type'(req_operation) == gps_pkg::OP_WRITE) |=> !$rose(rsp_valid))
      else $error("response after a cost write");

   // zero-total flag always comes with index 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> (rsp_selected_index == '0))
      else $error("zero-total status with nonzero index");

endmodule

bind ga_parent_selector gps_checker u_gps_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_operation      (req_chan.operation),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_selected_index (rsp_chan.selected_index),
   .rsp_status         (rsp_chan.status)
);
